### hdl/gbn_pkg.sv
// gbn_pkg: shared constants, codes and controller/datapath link types
// for the go-back-n sender; no dependencies
package gbn_pkg;

    // sequence and window sizing
    localparam int SEQ_BITS   = 16;
    localparam int TOP_W      = 17;
    localparam int WS_W       = 5;
    localparam int MAX_WINDOW = 16;
    localparam int CFG_W      = 16;

    // register reset values
    localparam logic [SEQ_BITS-1:0] FRAME_COUNT_RESET = SEQ_BITS'(8);
    localparam logic [WS_W-1:0]     WINDOW_SIZE_RESET = WS_W'(4);

    // event codes on the input channel
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_ACK     = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;
    localparam logic [1:0] EV_NONE    = 2'd3;

    // configuration register indexes
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_WINDOW_SIZE = 1'b1;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EXIT  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic loop_emit;
        logic exit_emit;
        logic ack_update;
        logic post_emit;
    } gbn_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic active;
        logic out_free;
        logic loop_more;
        logic loop_last;
        logic exit_hit;
        logic post_ok;
    } gbn_stat_t;

endpackage

### hdl/gbn_dp.sv
// gbn_dp: datapath of the go-back-n sender: config registers, window
// state, frame counter and the output register; uses gbn_pkg
module gbn_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_index,
    input  logic [gbn_pkg::CFG_W-1:0]      cfg_data,
    input  logic [1:0]                     cmd,
    input  logic [gbn_pkg::SEQ_BITS-1:0]   ack_number,
    input  gbn_pkg::gbn_cmd_t              ctrl,
    output gbn_pkg::gbn_stat_t             stat,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic                           kind,
    output logic [gbn_pkg::SEQ_BITS-1:0]   frame_number,
    output logic                           last
);
    import gbn_pkg::*;

    localparam int CNT_W  = SEQ_BITS + 1;
    localparam int DIFF_W = TOP_W + 1;

    logic [SEQ_BITS-1:0] frame_count_reg;
    logic [WS_W-1:0]     window_size_reg;
    logic [SEQ_BITS-1:0] base_reg;
    logic [TOP_W-1:0]    top_reg;
    logic [SEQ_BITS-1:0] next_reg;
    logic                active_reg;
    logic [SEQ_BITS-1:0] cur_reg;
    logic [CNT_W-1:0]    end_reg;
    logic [SEQ_BITS-1:0] ack_reg;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [SEQ_BITS-1:0] out_frame_reg;
    logic                out_last_reg;

    logic [WS_W-1:0]     ws_eff;
    logic [CNT_W-1:0]    fc_ext;
    logic [CNT_W-1:0]    cur_ext;
    logic [CNT_W-1:0]    cur_p1;
    logic [DIFF_W-1:0]   win_diff;
    logic [DIFF_W-1:0]   ws_m1;
    logic [SEQ_BITS-1:0] start_next;
    logic                any_emit;

    // effective window: zero reads as one, clamp at the maximum
    always_comb
    begin
        if (window_size_reg == '0)
            ws_eff = WS_W'(1);
        else if (32'(window_size_reg) > MAX_WINDOW)
            ws_eff = WS_W'(MAX_WINDOW);
        else
            ws_eff = window_size_reg;
    end

    // status toward the controller
    always_comb
    begin
        fc_ext   = {1'b0, frame_count_reg};
        cur_ext  = {1'b0, cur_reg};
        cur_p1   = cur_ext + CNT_W'(1);
        win_diff = {1'b0, top_reg} - {2'b00, base_reg};
        ws_m1    = DIFF_W'(ws_eff) - DIFF_W'(1);
        start_next = (frame_count_reg < SEQ_BITS'(ws_eff)) ? frame_count_reg
                                                           : SEQ_BITS'(ws_eff);
        any_emit = ctrl.loop_emit || ctrl.exit_emit || ctrl.post_emit;

        stat.active    = active_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
        stat.loop_more = (cur_ext < fc_ext) && (cur_ext < end_reg);
        stat.loop_last = !((cur_p1 < fc_ext) && (cur_p1 < end_reg));
        stat.exit_hit  = (({1'b0, ack_reg} + CNT_W'(1)) == fc_ext);
        stat.post_ok   = (win_diff != ws_m1) && (next_reg < frame_count_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT: frame_count_reg <= cfg_data[SEQ_BITS-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WS_W-1:0];
            endcase
        end
    end

    // window state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            top_reg       <= '0;
            next_reg      <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load && cmd == EV_START)
            begin
                base_reg   <= '0;
                top_reg    <= TOP_W'(ws_eff) - TOP_W'(1);
                next_reg   <= start_next;
                active_reg <= 1'b1;
            end
            if (ctrl.ack_update && ack_reg == base_reg)
                base_reg <= base_reg + SEQ_BITS'(1);
            if (ctrl.exit_emit)
                active_reg <= 1'b0;
            if (ctrl.post_emit)
            begin
                top_reg  <= top_reg + TOP_W'(1);
                next_reg <= next_reg + SEQ_BITS'(1);
            end
            if (any_emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // event scratch and output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ack_reg <= ack_number;
            if (cmd == EV_START)
            begin
                cur_reg <= '0;
                end_reg <= CNT_W'(ws_eff);
            end
            else
            begin
                cur_reg <= base_reg;
                end_reg <= {1'b0, base_reg} + CNT_W'(ws_eff);
            end
        end
        if (ctrl.loop_emit)
        begin
            out_kind_reg  <= KIND_FRAME;
            out_frame_reg <= cur_reg;
            out_last_reg  <= stat.loop_last;
            cur_reg       <= cur_p1[SEQ_BITS-1:0];
        end
        if (ctrl.exit_emit)
        begin
            out_kind_reg  <= KIND_EXIT;
            out_frame_reg <= '0;
            out_last_reg  <= 1'b1;
        end
        if (ctrl.post_emit)
        begin
            out_kind_reg  <= KIND_FRAME;
            out_frame_reg <= next_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign frame_number = out_frame_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    // a run only ends through an exit notice
    a_exit_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> out_valid_reg && out_kind_reg == KIND_EXIT)
        else $error("run ended without exit notice");
`endif

endmodule

### hdl/gbn_ctrl.sv
// gbn_ctrl: controller state machine of the go-back-n sender; sequences
// each event and issues datapath commands; uses gbn_pkg
module gbn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          cmd,
    output logic                in_stall,
    input  gbn_pkg::gbn_stat_t  stat,
    output gbn_pkg::gbn_cmd_t   ctrl
);
    import gbn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOP,
        ST_ACK,
        ST_POST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // commands
    always_comb
    begin
        accept          = in_valid && (state_reg == ST_IDLE);
        in_stall        = (state_reg != ST_IDLE);
        ctrl.load       = accept;
        ctrl.loop_emit  = (state_reg == ST_LOOP) && stat.loop_more && stat.out_free;
        ctrl.exit_emit  = (state_reg == ST_ACK) && stat.exit_hit && stat.out_free;
        ctrl.ack_update = (state_reg == ST_ACK) && !stat.exit_hit;
        ctrl.post_emit  = (state_reg == ST_POST) && stat.post_ok && stat.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        EV_START:   state_next = ST_LOOP;
                        EV_ACK:     state_next = stat.active ? ST_ACK : ST_IDLE;
                        EV_TIMEOUT: state_next = stat.active ? ST_LOOP : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOP:
            begin
                if (!stat.loop_more || (stat.out_free && stat.loop_last))
                    state_next = ST_IDLE;
            end
            ST_ACK:
            begin
                if (!stat.exit_hit)
                    state_next = ST_POST;
                else if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_POST:
            begin
                if (!stat.post_ok || stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.loop_emit || ctrl.exit_emit || ctrl.post_emit) |-> stat.out_free)
        else $error("emit into occupied output register");

    // a start always enters the send loop
    a_start_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == EV_START) |=> state_reg == ST_LOOP)
        else $error("start did not enter send loop");

    // the final loop frame returns to idle
    a_loop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.loop_emit && stat.loop_last) |=> state_reg == ST_IDLE)
        else $error("send loop did not finish on last frame");
`endif

endmodule

### hdl/go_back_n_sender.sv
// go_back_n_sender: top level of the go-back-n sender; joins gbn_ctrl and
// gbn_dp and uses gbn_pkg
// first result: loaded into the output register from ST_LOOP after a start or timeout,
// from ST_ACK after a final acknowledgment, and from ST_POST after ST_ACK for any other
// acknowledgment; ST_LOOP sends one frame per cycle while the output is free, and an
// event with no run active (other than a start) is dropped; one per cycle out when free
// reset: asynchronous, active low; idle with no run active, frame_count 8, window 4
module go_back_n_sender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [gbn_pkg::SEQ_BITS-1:0]   ack_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [gbn_pkg::SEQ_BITS-1:0]   frame_number,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [gbn_pkg::CFG_W-1:0]      cfg_data
);
    import gbn_pkg::*;

    gbn_cmd_t  ctrl;
    gbn_stat_t stat;

    // configuration writes are never stalled and are registered in the following cycle
    assign cfg_ready = 1'b1;

    // controller
    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // datapath
    gbn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .ack_number   (ack_number),
        .ctrl         (ctrl),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .frame_number (frame_number),
        .last         (last)
    );

endmodule
